// File: rtl/sfod_pkg.sv
// shared types and constants for the spectral flux onset detector
`default_nettype none

package sfod_pkg;

    localparam int FLUX_W = 20;
    localparam int THR_W  = 21;
    localparam int MAG_W  = 16;
    localparam int CFG_W  = 20;
    localparam int CIDX_W = 1;

    localparam logic [FLUX_W-1:0] FLUX_MAX   = '1;
    localparam logic [FLUX_W-1:0] THR_RESET  = 20'd2;

    typedef enum logic {
        OP_BIN   = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FLUX_THRESHOLD = 1'b0,
        CFG_ADAPTIVE_MODE  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              op;
        logic [MAG_W-1:0]  bin_magnitude;
    } t_in_item;

    typedef struct packed {
        logic [FLUX_W-1:0] flux;
        logic [THR_W-1:0]  threshold_used;
        logic              onset;
    } t_out_item;

    typedef struct packed {
        logic              accept;
        logic              clear;
    } t_row_ctl;

endpackage

`default_nettype wire

// File: rtl/spectral_flux_onset_detector.sv
// top level: bin cell row, history cell row and threshold pipeline
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_in_item  (op, bin_magnitude)
//  result    out        o_out_valid / i_out_stall o_out_item (flux, threshold_used, onset)
//  config    in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// one item per cycle while o_in_stall is low; a frame result leaves after its last
// bin has passed the frame, history, multiply and output stages
// reset zeroes all cells at once, no clearing pass
// up to four results queue in the stages; input stalls only once the frame
// stage is full and blocked
`default_nettype none

module spectral_flux_onset_detector #(
    parameter int NUM_BINS      = 16,
    parameter int HISTORY_DEPTH = 32,
    parameter int MAG_BITS      = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire sfod_pkg::t_in_item          i_in_item,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output sfod_pkg::t_out_item              o_out_item,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [sfod_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic [sfod_pkg::CFG_W-1:0]  i_cfg_data
);

    import sfod_pkg::*;

    localparam int TW  = FLUX_W + $clog2(HISTORY_DEPTH);
    localparam int DIV = 2 * HISTORY_DEPTH;
    localparam int DW  = $clog2(DIV);
    localparam int SH  = TW + DW;
    localparam int MW  = TW + 2;
    localparam int PW  = TW + MW;
    localparam logic [63:0] L_MULT_FULL =
        ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [MW-1:0] L_MULT = L_MULT_FULL[MW-1:0];

    // configuration
    logic [FLUX_W-1:0] r_flux_threshold;
    logic              r_adaptive_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flux_threshold <= THR_RESET;
            r_adaptive_mode  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FLUX_THRESHOLD: r_flux_threshold <= i_cfg_data[FLUX_W-1:0];
                CFG_ADAPTIVE_MODE:  r_adaptive_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage flow control
    logic r_b_valid, r_c_valid, r_d_valid, r_o_valid;
    logic w_out_free, w_d_free, w_c_free, w_b_free;
    logic w_d_adv, w_c_adv, w_b_adv;
    logic w_in_accept;

    always_comb begin
        w_out_free = !r_o_valid || !i_out_stall;
        w_d_adv    = r_d_valid && w_out_free;
        w_d_free   = !r_d_valid || w_out_free;
        w_c_adv    = r_c_valid && w_d_free;
        w_c_free   = !r_c_valid || w_d_free;
        w_b_adv    = r_b_valid && w_c_free;
        w_b_free   = !r_b_valid || w_c_free;
        w_in_accept = i_in_valid && w_b_free;
    end

    assign o_in_stall = !w_b_free;

    // bin row
    t_row_ctl          w_bin_ctl;
    logic              w_frame_done;
    logic [FLUX_W-1:0] w_flux;

    assign w_bin_ctl.accept = w_in_accept && (t_op'(i_in_item.op) == OP_BIN);
    assign w_bin_ctl.clear  = w_in_accept && (t_op'(i_in_item.op) == OP_CLEAR);

    sfod_bin_row #(
        .NUM_BINS (NUM_BINS),
        .MAG_BITS (MAG_BITS)
    ) u_bin_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_bin_ctl),
        .i_mag        (i_in_item.bin_magnitude),
        .o_frame_done (w_frame_done),
        .o_flux       (w_flux)
    );

    // frame stage
    logic [FLUX_W-1:0] r_b_flux;
    logic              r_b_adaptive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_frame_done) begin
            r_b_valid <= 1'b1;
        end else if (w_b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame_done) begin
            r_b_flux     <= w_flux;
            r_b_adaptive <= r_adaptive_mode;
        end
    end

    // history row, pushed as an adaptive frame leaves the frame stage
    t_row_ctl      w_hist_ctl;
    logic [TW-1:0] w_total_next;

    assign w_hist_ctl.accept = w_b_adv && r_b_adaptive;
    assign w_hist_ctl.clear  = w_bin_ctl.clear;

    sfod_hist_row #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_hist_ctl),
        .i_flux       (r_b_flux),
        .o_total_next (w_total_next)
    );

    // history stage
    logic [FLUX_W-1:0] r_c_flux;
    logic              r_c_adaptive;
    logic [TW-1:0]     r_c_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_b_adv) begin
            r_c_valid <= 1'b1;
        end else if (w_c_adv) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv) begin
            r_c_flux     <= r_b_flux;
            r_c_adaptive <= r_b_adaptive;
            r_c_total    <= w_total_next;
        end
    end

    // multiply stage: total / (2 * depth) by exact reciprocal
    logic [FLUX_W-1:0] r_d_flux;
    logic              r_d_adaptive;
    logic [PW-1:0]     r_d_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_c_adv) begin
            r_d_valid <= 1'b1;
        end else if (w_d_adv) begin
            r_d_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_adv) begin
            r_d_flux     <= r_c_flux;
            r_d_adaptive <= r_c_adaptive;
            r_d_prod     <= PW'(r_c_total) * PW'(L_MULT);
        end
    end

    // output stage
    logic [FLUX_W-1:0] w_quot;
    logic [THR_W-1:0]  w_thr;
    t_out_item         r_out;
    t_out_item         n_out;

    always_comb begin
        w_quot = r_d_prod[SH +: FLUX_W];
        w_thr  = r_d_adaptive ? (THR_W'(r_flux_threshold) + THR_W'(w_quot))
                              : THR_W'(r_flux_threshold);
        n_out.flux           = r_d_flux;
        n_out.threshold_used = w_thr;
        n_out.onset          = (THR_W'(r_d_flux) > w_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_d_adv) begin
            r_o_valid <= 1'b1;
        end else if (w_out_free) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: rtl/sfod_cell.sv
// one storage cell of a shifting chain, cleared as a whole
`default_nettype none

module sfod_cell #(
    parameter int WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_shift,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_clear) begin
            n_q = '0;
        end else if (i_shift) begin
            n_q = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: rtl/sfod_bin_row.sv
// row of previous-bin cells with the per-frame flux accumulator
`default_nettype none

module sfod_bin_row #(
    parameter int NUM_BINS = 16,
    parameter int MAG_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sfod_pkg::t_row_ctl         i_ctl,
    input  wire logic [sfod_pkg::MAG_W-1:0] i_mag,
    output logic                            o_frame_done,
    output logic [sfod_pkg::FLUX_W-1:0]     o_flux
);

    import sfod_pkg::*;

    localparam int PW = $clog2(NUM_BINS);
    localparam int SW = ((MAG_BITS > FLUX_W) ? MAG_BITS : FLUX_W) + 1;
    localparam logic [PW-1:0] L_LAST = PW'(NUM_BINS - 1);

    logic [MAG_BITS-1:0] w_cell_q [NUM_BINS];
    logic [MAG_BITS-1:0] w_mag;
    logic [MAG_BITS-1:0] w_diff;
    logic [SW-1:0]       w_sum;
    logic [FLUX_W-1:0]   w_flux;
    logic                w_last;

    logic [PW-1:0]       r_pos;
    logic [PW-1:0]       n_pos;
    logic [FLUX_W-1:0]   r_acc;
    logic [FLUX_W-1:0]   n_acc;

    // the head cell always holds the previous value of the bin now arriving
    for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
        logic [MAG_BITS-1:0] w_d;
        if (g == NUM_BINS - 1) begin : g_tail
            assign w_d = w_mag;
        end else begin : g_mid
            assign w_d = w_cell_q[g+1];
        end
        sfod_cell #(
            .WIDTH (MAG_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (i_ctl.clear),
            .i_shift (i_ctl.accept),
            .i_d     (w_d),
            .o_q     (w_cell_q[g])
        );
    end

    always_comb begin
        w_mag  = MAG_BITS'(i_mag);
        w_diff = (w_mag > w_cell_q[0]) ? (w_mag - w_cell_q[0]) : '0;
        w_sum  = SW'(r_acc) + SW'(w_diff);
        w_flux = (w_sum > SW'(FLUX_MAX)) ? FLUX_MAX : w_sum[FLUX_W-1:0];
        w_last = (r_pos == L_LAST);
    end

    always_comb begin
        n_pos = r_pos;
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_pos = '0;
            n_acc = '0;
        end else if (i_ctl.accept) begin
            n_pos = w_last ? '0 : r_pos + PW'(1);
            n_acc = w_last ? '0 : w_flux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
        end else begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

    assign o_frame_done = i_ctl.accept && w_last;
    assign o_flux       = w_flux;

endmodule

`default_nettype wire

// File: rtl/sfod_hist_row.sv
// row of flux history cells with the running history total
`default_nettype none

module sfod_hist_row #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sfod_pkg::t_row_ctl              i_ctl,
    input  wire logic [sfod_pkg::FLUX_W-1:0]     i_flux,
    output logic [sfod_pkg::FLUX_W + $clog2(HISTORY_DEPTH)-1:0] o_total_next
);

    import sfod_pkg::*;

    localparam int TW = FLUX_W + $clog2(HISTORY_DEPTH);

    logic [FLUX_W-1:0] w_cell_q [HISTORY_DEPTH];
    logic [TW-1:0]     w_total_next;
    logic [TW-1:0]     r_total;
    logic [TW-1:0]     n_total;

    // head cell is the oldest entry, the new flux enters at the tail
    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        logic [FLUX_W-1:0] w_d;
        if (g == HISTORY_DEPTH - 1) begin : g_tail
            assign w_d = i_flux;
        end else begin : g_mid
            assign w_d = w_cell_q[g+1];
        end
        sfod_cell #(
            .WIDTH (FLUX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (i_ctl.clear),
            .i_shift (i_ctl.accept),
            .i_d     (w_d),
            .o_q     (w_cell_q[g])
        );
    end

    assign w_total_next = r_total - TW'(w_cell_q[0]) + TW'(i_flux);

    always_comb begin
        n_total = r_total;
        if (i_ctl.clear) begin
            n_total = '0;
        end else if (i_ctl.accept) begin
            n_total = w_total_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    assign o_total_next = w_total_next;

endmodule

`default_nettype wire
